@@ hdl/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants of the sensor-to-servo scaler
// Payload structs, configuration register map, datapath command bundle.
// ----------------------------------------------------------------------------
package sss_pkg;

   localparam int unsigned DataWidth  = 16;
   localparam int unsigned IndexWidth = 3;
   localparam int unsigned DivSteps   = 16;
   localparam int unsigned CountWidth = 4;

   // Configuration register indexes
   typedef enum logic [IndexWidth-1:0] {
      REG_USE_CALIBRATION = 3'd0,
      REG_SMOOTH_ENABLE   = 3'd1,
      REG_FIXED_OFFSET    = 3'd2,
      REG_FIXED_SPAN      = 3'd3,
      REG_SERVO_MIN       = 3'd4,
      REG_SERVO_MAX       = 3'd5,
      REG_SERVO_SPAN      = 3'd6,
      REG_SLEW_STEP       = 3'd7
   } reg_index_type;

   // Reset values of the configuration registers
   localparam logic                 USE_CALIBRATION_RESET = 1'b1;
   localparam logic                 SMOOTH_ENABLE_RESET   = 1'b0;
   localparam logic [DataWidth-1:0] FIXED_OFFSET_RESET    = 16'd0;
   localparam logic [DataWidth-1:0] FIXED_SPAN_RESET      = 16'd4095;
   localparam logic [DataWidth-1:0] SERVO_MIN_RESET       = 16'd1000;
   localparam logic [DataWidth-1:0] SERVO_MAX_RESET       = 16'd2000;
   localparam logic [DataWidth-1:0] SERVO_SPAN_RESET      = 16'd1000;
   localparam logic [DataWidth-1:0] SLEW_STEP_RESET       = 16'd10;

   typedef struct packed {
      logic [DataWidth-1:0] hall_value;
      logic [DataWidth-1:0] cal_min;
      logic [DataWidth-1:0] cal_max;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] target_position;
      logic [DataWidth-1:0] drive_value;
      logic                 drive_written;
      logic                 range_error;
   } rsp_type;

   typedef struct packed {
      logic                 use_calibration;
      logic                 smooth_enable;
      logic [DataWidth-1:0] fixed_offset;
      logic [DataWidth-1:0] fixed_span;
      logic [DataWidth-1:0] servo_min;
      logic [DataWidth-1:0] servo_max;
      logic [DataWidth-1:0] servo_span;
      logic [DataWidth-1:0] slew_step;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture the request and window bounds
      logic prep;      // clamp the sample, form offset and span
      logic mul;       // multiply offset by servo span
      logic div_step;  // one restoring division step
      logic finish;    // clamp target, update drive, fill result register
   } cmd_type;

endpackage

@@ hdl/sss_csr.sv @@
// ----------------------------------------------------------------------------
// sss_csr: configuration registers
// Eight write-only registers, one transfer per cycle, always ready.
// ----------------------------------------------------------------------------
module sss_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sss_pkg::IndexWidth-1:0]      csr_index,
   input  logic [sss_pkg::DataWidth-1:0]       csr_data,
   output sss_pkg::cfg_type                    cfg
);

   sss_pkg::cfg_type cfg_ff;
   sss_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (sss_pkg::reg_index_type'(csr_index))
            sss_pkg::REG_USE_CALIBRATION: cfg_in.use_calibration = csr_data[0];
            sss_pkg::REG_SMOOTH_ENABLE:   cfg_in.smooth_enable   = csr_data[0];
            sss_pkg::REG_FIXED_OFFSET:    cfg_in.fixed_offset    = csr_data;
            sss_pkg::REG_FIXED_SPAN:      cfg_in.fixed_span      = csr_data;
            sss_pkg::REG_SERVO_MIN:       cfg_in.servo_min       = csr_data;
            sss_pkg::REG_SERVO_MAX:       cfg_in.servo_max       = csr_data;
            sss_pkg::REG_SERVO_SPAN:      cfg_in.servo_span      = csr_data;
            sss_pkg::REG_SLEW_STEP:       cfg_in.slew_step       = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_calibration <= sss_pkg::USE_CALIBRATION_RESET;
         cfg_ff.smooth_enable   <= sss_pkg::SMOOTH_ENABLE_RESET;
         cfg_ff.fixed_offset    <= sss_pkg::FIXED_OFFSET_RESET;
         cfg_ff.fixed_span      <= sss_pkg::FIXED_SPAN_RESET;
         cfg_ff.servo_min       <= sss_pkg::SERVO_MIN_RESET;
         cfg_ff.servo_max       <= sss_pkg::SERVO_MAX_RESET;
         cfg_ff.servo_span      <= sss_pkg::SERVO_SPAN_RESET;
         cfg_ff.slew_step       <= sss_pkg::SLEW_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/sss_ctrl.sv @@
// ----------------------------------------------------------------------------
// sss_ctrl: sequencing controller
// Steps one item through prep, multiply, divide and finish; owns the
// handshakes of the request and result channels.
// ----------------------------------------------------------------------------
module sss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sss_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type                         state_ff,     state_in;
   logic [sss_pkg::CountWidth-1:0]    count_ff,     count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Commands to the datapath
   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.prep     = (state_ff == ST_PREP);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.finish   = (state_ff == ST_FIN) && slot_free;
   end

   // Next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DIV;
            count_in = '0;
         end
         ST_DIV: begin
            count_in = count_ff + 1'b1;
            if (count_ff == sss_pkg::CountWidth'(sss_pkg::DivSteps - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/sss_dp.sv @@
// ----------------------------------------------------------------------------
// sss_dp: scaler datapath
// Window select and clamp, 16x16 multiply, serial restoring divider,
// servo clamp, slew limiter and result register.
// ----------------------------------------------------------------------------
module sss_dp (
   input  logic              clock,
   input  logic              reset,
   input  sss_pkg::cmd_type  cmd,
   input  sss_pkg::cfg_type  cfg,
   input  sss_pkg::req_type  req_data,
   output sss_pkg::rsp_type  rsp_data
);

   localparam int unsigned W = sss_pkg::DataWidth;

   logic [W-1:0]   val_ff,   val_in;
   logic [W-1:0]   lo_ff,    lo_in;
   logic [W:0]     hi_ff,    hi_in;
   logic [W-1:0]   diff_ff,  diff_in;
   logic [W-1:0]   span_ff,  span_in;
   logic           err_ff,   err_in;
   logic [W-1:0]   rem_ff,   rem_in;
   logic [W-1:0]   quo_ff,   quo_in;
   logic [W-1:0]   drive_ff, drive_in;
   sss_pkg::rsp_type rsp_ff, rsp_in;

   logic [W:0]     val_clamped;
   logic [2*W-1:0] product;
   logic [W:0]     trial;
   logic [W:0]     raw;
   logic [W-1:0]   target;
   logic           step_up;
   logic           step_down;
   logic           written;

   assign rsp_data = rsp_ff;

   // Window bounds at capture; the fixed upper bound is kept at 17 bits
   always_comb begin
      val_in = val_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      if (cmd.load) begin
         val_in = req_data.hall_value;
         if (cfg.use_calibration) begin
            lo_in = req_data.cal_min;
            hi_in = {1'b0, req_data.cal_max};
         end else begin
            lo_in = cfg.fixed_offset;
            hi_in = {1'b0, cfg.fixed_offset} + {1'b0, cfg.fixed_span};
         end
      end
   end

   // Clamp sample into window, form offset and span
   always_comb begin
      if ({1'b0, val_ff} > hi_ff) begin
         val_clamped = hi_ff;
      end else if (val_ff < lo_ff) begin
         val_clamped = {1'b0, lo_ff};
      end else begin
         val_clamped = {1'b0, val_ff};
      end
      diff_in = diff_ff;
      span_in = span_ff;
      err_in  = err_ff;
      if (cmd.prep) begin
         err_in  = (hi_ff <= {1'b0, lo_ff});
         diff_in = W'(val_clamped - {1'b0, lo_ff});
         span_in = W'(hi_ff - {1'b0, lo_ff});
      end
   end

   // Multiply, then restoring division; the quotient fits 16 bits, so the
   // upper product half starts as the partial remainder
   assign product = diff_ff * cfg.servo_span;
   assign trial   = {rem_ff, quo_ff[W-1]};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.mul) begin
         rem_in = product[2*W-1:W];
         quo_in = product[W-1:0];
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, span_ff}) begin
            rem_in = W'(trial - {1'b0, span_ff});
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
      end
   end

   // Servo offset and clamp; the upper bound is tested first
   always_comb begin
      raw = err_ff ? {1'b0, cfg.servo_min} : ({1'b0, quo_ff} + {1'b0, cfg.servo_min});
      if (raw > {1'b0, cfg.servo_max}) begin
         target = cfg.servo_max;
      end else if (raw < {1'b0, cfg.servo_min}) begin
         target = cfg.servo_min;
      end else begin
         target = raw[W-1:0];
      end
   end

   // Slew limiter: when smoothing is enabled, step only when more than one step away
   assign step_up   = ({1'b0, drive_ff} + {1'b0, cfg.slew_step}) < {1'b0, target};
   assign step_down = {1'b0, drive_ff} > ({1'b0, target} + {1'b0, cfg.slew_step});

   always_comb begin
      drive_in = drive_ff;
      written  = 1'b0;
      if (!cfg.smooth_enable) begin
         drive_in = target;
         written  = 1'b1;
      end else if (step_up) begin
         drive_in = drive_ff + cfg.slew_step;
         written  = 1'b1;
      end else if (step_down) begin
         drive_in = drive_ff - cfg.slew_step;
         written  = 1'b1;
      end
   end

   // Result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.target_position = target;
         rsp_in.drive_value     = drive_in;
         rsp_in.drive_written   = written;
         rsp_in.range_error     = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      diff_ff <= diff_in;
      span_ff <= span_in;
      err_ff  <= err_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      rsp_ff  <= rsp_in;
   end

   // Kept drive value
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= sss_pkg::SERVO_MAX_RESET;
      end else if (cmd.finish) begin
         drive_ff <= drive_in;
      end
   end

endmodule

@@ hdl/sensor_to_servo_scaler_slew_top.sv @@
// ----------------------------------------------------------------------------
// sensor_to_servo_scaler_slew_top: hall sample to servo compare value
// Linear range map with servo clamp and optional slew limiting.
// ----------------------------------------------------------------------------
// One item is processed at a time. After the request transfer the item passes
// the clamp (prep) state, the multiply state, the restoring divider at one
// quotient bit per cycle, and the finish state, which fills the result
// register. The next request is taken only once the controller is back in
// idle. A result waits in its own register, so the next request is taken
// while the previous result is still unclaimed; a new result is held back only
// until that register frees. Configuration writes are to be made by the user
// only while idle; the block itself does not enforce this.
module sensor_to_servo_scaler_slew_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sss_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sss_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sss_pkg::IndexWidth-1:0] csr_index,
   input  logic [sss_pkg::DataWidth-1:0]  csr_data
);

   sss_pkg::cfg_type cfg;
   sss_pkg::cmd_type cmd;

   sss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sss_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

@@ tb/sv/servo_map_checker.sv @@
// ----------------------------------------------------------------------------
// servo_map_checker: result predictor and comparator for the servo scaler
// Watches the request, result and register channels of the scaler. Keeps its
// own copy of the registers and of the driven servo value, works out the
// expected result of every request transfer and compares each result
// transfer, field by field, against the oldest one still waiting.
// ----------------------------------------------------------------------------
module servo_map_checker
   import sss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]  csr_data,
   output int                    mismatches,
   output int                    pending_results,
   output int                    results_seen
);

   cfg_type              cfg_shadow;
   logic [DataWidth-1:0] drive_model;
   rsp_type              servo_results_q[$];
   rsp_type              want;
   int                   fails;
   int                   seen;

   // Expected result of one sample, given the registers and the current drive
   function automatic rsp_type map_sample(input req_type item, input cfg_type c,
                                          input logic [DataWidth-1:0] drive);
      logic [16:0]          lo;
      logic [16:0]          hi;
      logic [16:0]          val;
      logic [16:0]          span;
      logic [31:0]          offs;
      logic [31:0]          prod;
      logic [31:0]          raw;
      logic [DataWidth-1:0] tgt16;
      int                   cur;
      int                   tgt;
      int                   stp;
      rsp_type              r;
      r = '0;
      // sensor window: per-item bounds or fixed offset/span (17-bit top)
      if (c.use_calibration) begin
         lo = {1'b0, item.cal_min};
         hi = {1'b0, item.cal_max};
      end else begin
         lo = {1'b0, c.fixed_offset};
         hi = {1'b0, c.fixed_offset} + {1'b0, c.fixed_span};
      end
      // empty or inverted window: no division, flag it
      if (hi <= lo) begin
         r.range_error = 1'b1;
         raw = {16'd0, c.servo_min};
      end else begin
         span = hi - lo;
         val  = {1'b0, item.hall_value};
         if (val > hi) begin
            val = hi;
         end else if (val < lo) begin
            val = lo;
         end
         offs = val - lo;
         prod = offs * c.servo_span;
         raw  = prod / span;
         raw  = raw + c.servo_min;
      end
      // servo clamp, upper bound tested first
      if (raw > c.servo_max) begin
         tgt16 = c.servo_max;
      end else if (raw < c.servo_min) begin
         tgt16 = c.servo_min;
      end else begin
         tgt16 = raw[DataWidth-1:0];
      end
      r.target_position = tgt16;
      // drive update: direct, or one step when outside the dead band
      if (c.smooth_enable) begin
         cur = drive;
         tgt = tgt16;
         stp = c.slew_step;
         r.drive_value = drive;
         if (cur < tgt - stp) begin
            r.drive_value   = drive + c.slew_step;
            r.drive_written = 1'b1;
         end else if (cur > tgt + stp) begin
            r.drive_value   = drive - c.slew_step;
            r.drive_written = 1'b1;
         end
      end else begin
         r.drive_value   = tgt16;
         r.drive_written = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_shadow.use_calibration = USE_CALIBRATION_RESET;
         cfg_shadow.smooth_enable   = SMOOTH_ENABLE_RESET;
         cfg_shadow.fixed_offset    = FIXED_OFFSET_RESET;
         cfg_shadow.fixed_span      = FIXED_SPAN_RESET;
         cfg_shadow.servo_min       = SERVO_MIN_RESET;
         cfg_shadow.servo_max       = SERVO_MAX_RESET;
         cfg_shadow.servo_span      = SERVO_SPAN_RESET;
         cfg_shadow.slew_step       = SLEW_STEP_RESET;
         drive_model = SERVO_MAX_RESET;
         servo_results_q.delete();
         fails = 0;
         seen  = 0;
      end else begin
         // result transfer: compare with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (servo_results_q.size() == 0) begin
               $error("unexpected result: target %0d drive %0d",
                      rsp_data.target_position, rsp_data.drive_value);
               fails++;
            end else begin
               want = servo_results_q.pop_front();
               seen++;
               if (rsp_data.target_position !== want.target_position) begin
                  $error("target_position: expected %0d, actual %0d",
                         want.target_position, rsp_data.target_position);
                  fails++;
               end
               if (rsp_data.drive_value !== want.drive_value) begin
                  $error("drive_value: expected %0d, actual %0d",
                         want.drive_value, rsp_data.drive_value);
                  fails++;
               end
               if (rsp_data.drive_written !== want.drive_written) begin
                  $error("drive_written: expected %0d, actual %0d",
                         want.drive_written, rsp_data.drive_written);
                  fails++;
               end
               if (rsp_data.range_error !== want.range_error) begin
                  $error("range_error: expected %0d, actual %0d",
                         want.range_error, rsp_data.range_error);
                  fails++;
               end
            end
         end
         // request transfer: predict and queue
         if (req_valid && req_ready) begin
            want = map_sample(req_data, cfg_shadow, drive_model);
            drive_model = want.drive_value;
            servo_results_q.push_back(want);
         end
         // register write
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_USE_CALIBRATION: cfg_shadow.use_calibration = csr_data[0];
               REG_SMOOTH_ENABLE:   cfg_shadow.smooth_enable   = csr_data[0];
               REG_FIXED_OFFSET:    cfg_shadow.fixed_offset    = csr_data;
               REG_FIXED_SPAN:      cfg_shadow.fixed_span      = csr_data;
               REG_SERVO_MIN:       cfg_shadow.servo_min       = csr_data;
               REG_SERVO_MAX:       cfg_shadow.servo_max       = csr_data;
               REG_SERVO_SPAN:      cfg_shadow.servo_span      = csr_data;
               REG_SLEW_STEP:       cfg_shadow.slew_step       = csr_data;
               default: ;
            endcase
         end
      end
      mismatches      <= fails;
      pending_results <= servo_results_q.size();
      results_seen    <= seen;
   end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the sensor-to-servo scaler
// Drives hall samples and register settings into the scaler with random gaps
// on both channels, one long output stall, a directed set of corner samples
// and about a thousand random ones across many settings. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import sss_pkg::*;

   localparam int          TOTAL_SAMPLES = 1000;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int unsigned HOLD_AT       = 300;
   localparam int unsigned HOLD_CYCLES   = 400;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [IndexWidth-1:0] csr_index = '0;
   logic [DataWidth-1:0]  csr_data  = '0;

   int      mismatches;
   int      pending_results;
   int      results_seen;
   int      cycle_count   = 0;
   int      sample_count  = 0;
   int      setting_count = 0;
   bit      idle_off      = 1'b0;
   cfg_type cfg;

   sensor_to_servo_scaler_slew_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   servo_map_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .pending_results (pending_results),
      .results_seen    (results_seen)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // result side: random stall per transfer, one long hold-off
   initial begin
      int unsigned stall;
      int unsigned taken;
      taken = 0;
      forever begin
         stall = idle_off ? 0 : $urandom_range(0, 8);
         if (taken == HOLD_AT) begin
            stall = HOLD_CYCLES;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // one request transfer after a random gap; valid stays up across gap 0
   task automatic offer_sample(input req_type item);
      int unsigned gap;
      gap = idle_off ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sample_count++;
   endtask

   // wait until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [DataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // write the whole register set back to back
   task automatic program_settings(input cfg_type c);
      write_reg(REG_USE_CALIBRATION, {15'd0, c.use_calibration});
      write_reg(REG_SMOOTH_ENABLE, {15'd0, c.smooth_enable});
      write_reg(REG_FIXED_OFFSET, c.fixed_offset);
      write_reg(REG_FIXED_SPAN, c.fixed_span);
      write_reg(REG_SERVO_MIN, c.servo_min);
      write_reg(REG_SERVO_MAX, c.servo_max);
      write_reg(REG_SERVO_SPAN, c.servo_span);
      write_reg(REG_SLEW_STEP, c.slew_step);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   function automatic req_type make_sample(input logic [DataWidth-1:0] hall,
                                           input logic [DataWidth-1:0] lo,
                                           input logic [DataWidth-1:0] hi);
      req_type item;
      item.hall_value = hall;
      item.cal_min    = lo;
      item.cal_max    = hi;
      return item;
   endfunction

   // value biased toward the 16-bit extremes
   function automatic logic [DataWidth-1:0] pick_edge16(input int unsigned hi_lim);
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, hi_lim));
      endcase
   endfunction

   task automatic draw_settings();
      int unsigned lo_s;
      cfg.use_calibration = ($urandom_range(0, 3) != 0);
      cfg.smooth_enable   = $urandom_range(0, 1);
      cfg.fixed_offset    = pick_edge16(8000);
      cfg.fixed_span      = pick_edge16(8000);
      if ($urandom_range(0, 5) == 0) begin
         // anything, inverted servo bounds included
         cfg.servo_min = pick_edge16(65535);
         cfg.servo_max = pick_edge16(65535);
      end else begin
         lo_s          = $urandom_range(0, 40000);
         cfg.servo_min = lo_s;
         cfg.servo_max = lo_s + $urandom_range(0, 65535 - lo_s);
      end
      if ($urandom_range(0, 4) == 0) begin
         cfg.servo_span = pick_edge16(65535);
      end else begin
         cfg.servo_span = cfg.servo_max - cfg.servo_min;
      end
      if ($urandom_range(0, 5) == 0) begin
         cfg.slew_step = pick_edge16(65535);
      end else begin
         cfg.slew_step = $urandom_range(0, 300);
      end
   endtask

   // mostly samples inside a sane window; some noise, empty and inverted bounds
   function automatic req_type draw_sample();
      int unsigned lo;
      int unsigned hi;
      int unsigned kind;
      req_type     item;
      kind            = $urandom_range(0, 9);
      item.hall_value = 16'($urandom());
      item.cal_min    = 16'($urandom());
      item.cal_max    = 16'($urandom());
      if (kind == 1) begin
         item.cal_max = item.cal_min;
      end else if (kind == 2) begin
         if (item.cal_max > item.cal_min) begin
            {item.cal_min, item.cal_max} = {item.cal_max, item.cal_min};
         end
      end else if (kind > 2) begin
         if (cfg.use_calibration) begin
            lo           = $urandom_range(0, 60000);
            hi           = lo + $urandom_range(1, 65535 - lo);
            item.cal_min = lo;
            item.cal_max = hi;
         end else begin
            lo = cfg.fixed_offset;
            hi = lo + cfg.fixed_span;
            if (hi > 65535) begin
               hi = 65535;
            end
         end
         if (kind != 3) begin
            item.hall_value = $urandom_range(lo, hi);
         end
      end
      return item;
   endfunction

   initial begin
      int unsigned n;
      int          errors;
      cfg.use_calibration = USE_CALIBRATION_RESET;
      cfg.smooth_enable   = SMOOTH_ENABLE_RESET;
      cfg.fixed_offset    = FIXED_OFFSET_RESET;
      cfg.fixed_span      = FIXED_SPAN_RESET;
      cfg.servo_min       = SERVO_MIN_RESET;
      cfg.servo_max       = SERVO_MAX_RESET;
      cfg.servo_span      = SERVO_SPAN_RESET;
      cfg.slew_step       = SLEW_STEP_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: calibrated window, direct drive
      offer_sample(make_sample(16'd0, 16'd0, 16'hFFFF));
      offer_sample(make_sample(16'hFFFF, 16'd0, 16'hFFFF));
      offer_sample(make_sample(16'd500, 16'd1000, 16'd3000));
      offer_sample(make_sample(16'd4000, 16'd1000, 16'd3000));
      offer_sample(make_sample(16'd2000, 16'd1000, 16'd3000));
      offer_sample(make_sample(16'd1234, 16'd777, 16'd777));
      offer_sample(make_sample(16'd1234, 16'd3000, 16'd1000));
      offer_sample(make_sample(16'hFFFF, 16'hFFFE, 16'hFFFF));
      settle();

      // fixed window reaching past 16 bits, full servo range
      cfg.use_calibration = 1'b0;
      cfg.fixed_offset    = 16'hFFFF;
      cfg.fixed_span      = 16'hFFFF;
      cfg.servo_min       = 16'd0;
      cfg.servo_max       = 16'hFFFF;
      cfg.servo_span      = 16'hFFFF;
      program_settings(cfg);
      offer_sample(make_sample(16'hFFFF, 16'd0, 16'd0));
      offer_sample(make_sample(16'd0, 16'hFFFF, 16'hFFFF));
      offer_sample(make_sample(16'h8000, 16'h5555, 16'hAAAA));
      settle();

      // fixed window of zero span
      cfg.fixed_offset = 16'd100;
      cfg.fixed_span   = 16'd0;
      cfg.servo_span   = 16'd0;
      program_settings(cfg);
      offer_sample(make_sample(16'd100, 16'd0, 16'd200));
      settle();

      // servo bounds inverted
      cfg.use_calibration = 1'b1;
      cfg.servo_min       = 16'd3000;
      cfg.servo_max       = 16'd2000;
      cfg.servo_span      = 16'd5000;
      program_settings(cfg);
      offer_sample(make_sample(16'd0, 16'd0, 16'd100));
      offer_sample(make_sample(16'd100, 16'd0, 16'd100));
      settle();

      // smooth drive: step down, step up, hold inside the dead band
      cfg.smooth_enable = 1'b1;
      cfg.servo_min     = 16'd1000;
      cfg.servo_max     = 16'd2000;
      cfg.servo_span    = 16'd1000;
      cfg.slew_step     = 16'd100;
      program_settings(cfg);
      offer_sample(make_sample(16'd0, 16'd0, 16'd1000));
      offer_sample(make_sample(16'd0, 16'd0, 16'd1000));
      offer_sample(make_sample(16'd1000, 16'd0, 16'd1000));
      offer_sample(make_sample(16'd950, 16'd0, 16'd1000));
      settle();

      // zero step and widest step
      cfg.slew_step = 16'd0;
      program_settings(cfg);
      offer_sample(make_sample(16'd900, 16'd0, 16'd1000));
      offer_sample(make_sample(16'd300, 16'd0, 16'd1000));
      settle();
      cfg.slew_step = 16'hFFFF;
      program_settings(cfg);
      offer_sample(make_sample(16'd1000, 16'd0, 16'd1000));
      settle();

      // random settings and samples; some settings run without any idling
      while (sample_count < TOTAL_SAMPLES) begin
         draw_settings();
         idle_off = (setting_count % 5 == 3);
         program_settings(cfg);
         n = $urandom_range(40, 90);
         repeat (n) offer_sample(draw_sample());
         settle();
      end
      idle_off = 1'b0;

      repeat (40) @(posedge clock);
      errors = mismatches + pending_results;
      $display("tb: %0d samples over %0d register settings, %0d results checked",
               sample_count, setting_count, results_seen);
      $display("tb: corner windows, inverted bounds, slew steps and a long output stall");
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/sss_pkg.sv
hdl/sss_csr.sv
hdl/sss_ctrl.sv
hdl/sss_dp.sv
hdl/sensor_to_servo_scaler_slew_top.sv
tb/sv/servo_map_checker.sv
tb/sv/tb.sv
